@@ design/itoa_pkg.sv @@
// ----------------------------------------------------------------------------
// itoa_pkg - shared types and constants for the integer to ASCII unit
// Beat structs, sequencer states, character codes and the digit mapping.
// ----------------------------------------------------------------------------
package itoa_pkg;

	// Fixed sizes
	localparam int unsigned DATA_W     = 32;
	localparam int unsigned RADIX_W    = 6;
	localparam int unsigned DIGIT_W    = 5;
	localparam int unsigned CHAR_W     = 7;
	localparam int unsigned MAX_DIGITS = 32;
	localparam int unsigned CNT_W      = $clog2(MAX_DIGITS + 1);

	// Divider: quotient bits resolved per cycle
	localparam int unsigned DIV_BITS  = 4;
	localparam int unsigned DIV_STEPS = DATA_W / DIV_BITS;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	// Radix limits
	localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd32;
	localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;

	// Character codes
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
	localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;

	// Input beat
	typedef struct packed {
		logic signed [DATA_W-1:0]  number;
		logic        [RADIX_W-1:0] radix;
	} itoa_in_t;

	// Output beat
	typedef struct packed {
		logic [CHAR_W-1:0] out_char;
		logic              last_char;
		logic              bad_radix;
	} itoa_out_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_SIGN,
		ST_DIGITS,
		ST_ERROR
	} itoa_state_t;

	// Digit value to ASCII: 0..9 -> '0'..'9', 10..31 -> 'A'..'V'
	function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] dx;
		dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
		if (d < 5'd10)
			return CHAR_ZERO + dx;
		else
			return CHAR_A + (dx - 7'd10);
	endfunction

endpackage

@@ design/itoa_div.sv @@
// ----------------------------------------------------------------------------
// itoa_div - iterative unsigned divider, 32-bit dividend by 6-bit divisor
// Restoring division, DIV_BITS quotient bits per cycle; pulses done when
// quotient and remainder are ready.
// ----------------------------------------------------------------------------
module itoa_div
	import itoa_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  logic [DATA_W-1:0]   dividend,
	input  logic [RADIX_W-1:0]  divisor,
	output logic                done,
	output logic [DATA_W-1:0]   quotient,
	output logic [DIGIT_W-1:0]  remainder
);

	logic                 run_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DATA_W-1:0]    quo_q;
	logic [RADIX_W-1:0]   rem_q;
	logic [RADIX_W-1:0]   dvs_q;
	logic [DATA_W-1:0]    quo_nxt;
	logic [RADIX_W-1:0]   rem_nxt;

	// Compare/subtract steps for one cycle
	always_comb begin
		logic [RADIX_W-1:0] r;
		logic [DATA_W-1:0]  q;
		r = rem_q;
		q = quo_q;
		for (int i = 0; i < DIV_BITS; i++) begin
			r = {r[RADIX_W-2:0], q[DATA_W-1]};
			q = {q[DATA_W-2:0], 1'b0};
			if (r >= dvs_q) begin
				r    = r - dvs_q;
				q[0] = 1'b1;
			end
		end
		rem_nxt = r;
		quo_nxt = q;
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			quo_q <= quo_nxt;
			rem_q <= rem_nxt;
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q[DIGIT_W-1:0];

endmodule

@@ design/itoa_stack.sv @@
// ----------------------------------------------------------------------------
// itoa_stack - digit LIFO
// Shift-register stack; entry 0 is the top. Digits are pushed least
// significant first and popped most significant first.
// ----------------------------------------------------------------------------
module itoa_stack
	import itoa_pkg::*;
(
	input  logic               clk,
	input  logic               push,
	input  logic               pop,
	input  logic [DIGIT_W-1:0] din,
	output logic [DIGIT_W-1:0] top
);

	logic [DIGIT_W-1:0] ent_q [MAX_DIGITS];

	// Shift down on push, up on pop
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[0] <= din;
			for (int i = 1; i < MAX_DIGITS; i++)
				ent_q[i] <= ent_q[i-1];
		end else if (pop) begin
			for (int i = 0; i < MAX_DIGITS - 1; i++)
				ent_q[i] <= ent_q[i+1];
		end
	end

	assign top = ent_q[0];

endmodule

@@ design/integer_to_ascii_radix_unit.sv @@
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_unit - signed 32-bit integer to ASCII, radix 2..32
// Sequencing: the magnitude is divided by the radix repeatedly in the shared
//   divider, one digit per division, each remainder pushed on the digit stack;
//   then one character beat per cycle, a minus sign first for a negative
//   number in radix 10 only, then the digits most significant first.
// A new item is accepted only when idle; a bad radix gives one error beat.
// busy is high from acceptance until the last beat is registered; the
//   receiver cannot stall results.
// Reset (arst_n low) returns the sequencer to idle and drops any conversion
//   in flight; no beat of it follows.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_unit
	import itoa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  itoa_in_t  operand,
	output logic      strobe,
	output itoa_out_t result
);

	itoa_state_t          state_q, state_nxt;
	logic                 neg_q;
	logic [RADIX_W-1:0]   radix_q;
	logic [CNT_W-1:0]     nd_q;
	logic                 strobe_q;
	itoa_out_t            result_q;

	logic                 accept;
	logic                 radix_ok;
	logic [DATA_W-1:0]    magnitude;
	logic                 more;

	logic                 div_go;
	logic [DATA_W-1:0]    div_dividend;
	logic [RADIX_W-1:0]   div_divisor;
	logic                 div_done;
	logic [DATA_W-1:0]    div_quo;
	logic [DIGIT_W-1:0]   div_rem;

	logic                 push, pop;
	logic [DIGIT_W-1:0]   stk_top;

	logic                 emit;
	itoa_out_t            emit_beat;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign radix_ok = (operand.radix >= RADIX_MIN) && (operand.radix <= RADIX_MAX);
	assign magnitude = operand.number[DATA_W-1] ? (~operand.number + 1'b1)
	                                            : operand.number;
	assign more     = (div_quo != '0) && ((nd_q + 1'b1) < CNT_W'(MAX_DIGITS));

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept)
					state_nxt = radix_ok ? ST_DIVIDE : ST_ERROR;
			end
			ST_DIVIDE: begin
				if (div_done && !more)
					state_nxt = (neg_q && radix_q == RADIX_DEC) ? ST_SIGN : ST_DIGITS;
			end
			ST_SIGN:   state_nxt = ST_DIGITS;
			ST_DIGITS: begin
				if (nd_q == CNT_W'(1))
					state_nxt = ST_IDLE;
			end
			ST_ERROR:  state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		div_go       = 1'b0;
		div_dividend = div_quo;
		div_divisor  = radix_q;
		push         = 1'b0;
		pop          = 1'b0;
		emit         = 1'b0;
		emit_beat    = '{out_char: CHAR_NONE, last_char: 1'b0, bad_radix: 1'b0};
		case (state_q)
			ST_IDLE: begin
				div_dividend = magnitude;
				div_divisor  = operand.radix;
				div_go       = accept && radix_ok;
			end
			ST_DIVIDE: begin
				push   = div_done;
				div_go = div_done && more;
			end
			ST_SIGN: begin
				emit      = 1'b1;
				emit_beat = '{out_char: CHAR_MINUS, last_char: 1'b0, bad_radix: 1'b0};
			end
			ST_DIGITS: begin
				emit      = 1'b1;
				pop       = 1'b1;
				emit_beat = '{out_char: digit_to_char(stk_top),
				              last_char: (nd_q == CNT_W'(1)), bad_radix: 1'b0};
			end
			ST_ERROR: begin
				emit      = 1'b1;
				emit_beat = '{out_char: CHAR_NONE, last_char: 1'b1, bad_radix: 1'b1};
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
			nd_q     <= '0;
		end else begin
			state_q  <= state_nxt;
			strobe_q <= emit;
			if (accept)
				nd_q <= '0;
			else if (push)
				nd_q <= nd_q + 1'b1;
			else if (pop)
				nd_q <= nd_q - 1'b1;
		end
	end

	// Item context and result beat
	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q   <= operand.number[DATA_W-1];
			radix_q <= operand.radix;
		end
		if (emit)
			result_q <= emit_beat;
	end

	itoa_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (div_go),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	itoa_stack u_stack (
		.clk  (clk),
		.push (push),
		.pop  (pop),
		.din  (div_rem),
		.top  (stk_top)
	);

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

@@ design/itoa_checker.sv @@
// ----------------------------------------------------------------------------
// itoa_checker - port-level checks for the integer to ASCII unit
// Watches the command and result ports; bound to the top level.
// ----------------------------------------------------------------------------
module itoa_checker
	import itoa_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input itoa_in_t  operand,
	input logic      strobe,
	input itoa_out_t result
);

	// Accepted command makes the unit busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accepted command");

	// Accepted command with an out-of-range radix answers with the error beat
	a_bad_radix: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (operand.radix < RADIX_MIN || operand.radix > RADIX_MAX)
		|=> ##1 strobe && result.bad_radix)
		else $error("no error beat for bad radix");

	// Error beat is a lone, final beat with a null character
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.bad_radix |-> result.last_char && result.out_char == CHAR_NONE)
		else $error("bad radix beat malformed");

	// Characters of one string come out back to back
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last_char |=> strobe)
		else $error("gap inside a string");

	// Last beat of a string lets the unit go idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last_char |-> !busy)
		else $error("unit still busy after last beat");

endmodule

bind integer_to_ascii_radix_unit itoa_checker u_itoa_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.operand (operand),
	.strobe  (strobe),
	.result  (result)
);
